// ===== hw/rtl/fwds_pkg.sv =====
// Shared types, codes and defaults of the firmware download sequencer.
package fwds_pkg;

  localparam int unsigned MaxBlockBytes = 4096;
  localparam int unsigned NoSlotCode    = 255;

  localparam int unsigned OpW     = 4;
  localparam int unsigned StatusW = 4;
  localparam int unsigned StateW  = 4;
  localparam int unsigned VerW    = 32;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned CntW    = 8;
  localparam int unsigned LenW    = 13;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [OpW-1:0] {
    OP_ARM      = 4'd0,
    OP_SESSION  = 4'd1,
    OP_SECURITY = 4'd2,
    OP_DTC      = 4'd3,
    OP_COMM     = 4'd4,
    OP_DOWNLOAD = 4'd5,
    OP_BLOCK    = 4'd6,
    OP_EXIT     = 4'd7,
    OP_CHECK    = 4'd8,
    OP_STAGE    = 4'd9,
    OP_CONFIRM  = 4'd10,
    OP_ABORT    = 4'd11
  } op_e;

  typedef enum logic [StateW-1:0] {
    ST_DISARMED    = 4'd0,
    ST_ARMED       = 4'd1,
    ST_SESSION     = 4'd2,
    ST_SECURED     = 4'd3,
    ST_QUIESCED    = 4'd4,
    ST_DOWNLOADING = 4'd5,
    ST_TRANSFERRED = 4'd6,
    ST_VERIFIED    = 4'd7,
    ST_STAGED      = 4'd8,
    ST_COMPLETE    = 4'd9,
    ST_FAILED      = 4'd10
  } sess_e;

  typedef enum logic [StatusW-1:0] {
    RC_OK        = 4'd0,
    RC_INVALID   = 4'd1,
    RC_BAD_STATE = 4'd2,
    RC_LOCKED    = 4'd3,
    RC_HOOK      = 4'd4,
    RC_ROLLBACK  = 4'd5,
    RC_SEQUENCE  = 4'd6,
    RC_SIZE      = 4'd7,
    RC_INTEGRITY = 4'd8,
    RC_AUTH      = 4'd9,
    RC_SECBOOT   = 4'd10
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALLOW_PROG  = 3'd0,
    CFG_REQ_SEC     = 3'd1,
    CFG_REQ_QUIESCE = 3'd2,
    CFG_REQ_AUTH    = 3'd3,
    CFG_REQ_SECBOOT = 3'd4,
    CFG_HOOKS_DONE  = 3'd5,
    CFG_ABORT_HOOK  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic prog_enable;
    logic need_sec_access;
    logic need_quiet;
    logic need_auth;
    logic require_secure_boot_check;
    logic hooks_complete;
    logic abort_hook_present;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic             flag_value;
    logic [VerW-1:0]  version;
    logic [SizeW-1:0] img_bytes;
    logic [CntW-1:0]  block_counter;
    logic [LenW-1:0]  block_length;
    logic             first_ok;
    logic             second_ok;
    logic [SlotW-1:0] chosen_slot;
  } item_t;

  typedef struct packed {
    sess_e            sess;
    logic [VerW-1:0]  inst_ver;
    logic [VerW-1:0]  cand_ver;
    logic [SizeW-1:0] cand_bytes;
    logic [SizeW-1:0] bytes_written;
    logic [SlotW-1:0] cand_slot;
    logic [CntW-1:0]  expected_counter;
    logic             dtc_off;
    logic             comm_off;
  } ctx_t;

  typedef struct packed {
    status_e          status;
    sess_e            sess;
    logic [SizeW-1:0] write_offset;
    logic [SlotW-1:0] target_slot;
    logic             abort_request;
  } result_t;

endpackage

// ===== hw/rtl/fwds_step.sv =====
// Next-state and result logic for one sequencer operation.
module fwds_step #(
  parameter int unsigned MAX_BLOCK_BYTES = fwds_pkg::MaxBlockBytes,
  parameter int unsigned NO_SLOT_CODE    = fwds_pkg::NoSlotCode
) (
  input  fwds_pkg::cfg_t    cfg_i,
  input  fwds_pkg::ctx_t    ctx_i,
  input  fwds_pkg::item_t   item_i,
  output fwds_pkg::ctx_t    ctx_o,
  output fwds_pkg::result_t res_o
);

  localparam logic [fwds_pkg::SlotW-1:0] NoSlot = fwds_pkg::SlotW'(NO_SLOT_CODE);
  localparam logic [31:0] MaxLen = 32'(MAX_BLOCK_BYTES);

  logic in_prog;
  logic prereq;

  assign in_prog = (ctx_i.sess == fwds_pkg::ST_SESSION) ||
                   (ctx_i.sess == fwds_pkg::ST_SECURED) ||
                   (ctx_i.sess == fwds_pkg::ST_QUIESCED);

  assign prereq = in_prog &&
                  (!cfg_i.need_sec_access ||
                   ctx_i.sess == fwds_pkg::ST_SECURED ||
                   ctx_i.sess == fwds_pkg::ST_QUIESCED) &&
                  (!cfg_i.need_quiet || (ctx_i.dtc_off && ctx_i.comm_off));

  always_comb begin
    fwds_pkg::ctx_t   nxt;
    fwds_pkg::status_e st;
    logic [fwds_pkg::SizeW-1:0] offset;
    logic [fwds_pkg::SlotW-1:0] slot_out;
    logic fail;
    logic abort_req;
    logic slot_fixed;
    fwds_pkg::sess_e fs;
    logic [fwds_pkg::SizeW-1:0] room;

    nxt        = ctx_i;
    st         = fwds_pkg::RC_OK;
    offset     = '0;
    slot_out   = ctx_i.cand_slot;
    fail       = 1'b0;
    abort_req  = 1'b0;
    slot_fixed = 1'b0;
    fs         = ctx_i.sess;
    room       = ctx_i.cand_bytes - ctx_i.bytes_written;

    case (item_i.operation) inside
      fwds_pkg::OP_ARM: begin
        if (ctx_i.sess != fwds_pkg::ST_DISARMED) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (!cfg_i.prog_enable || !cfg_i.hooks_complete) begin
          st = fwds_pkg::RC_LOCKED;
        end else if (!item_i.first_ok) begin
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else begin
          nxt.inst_ver = item_i.version;
          nxt.sess = fwds_pkg::ST_ARMED;
        end
      end
      fwds_pkg::OP_SESSION: begin
        if (ctx_i.sess != fwds_pkg::ST_ARMED) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else begin
          nxt.dtc_off  = 1'b0;
          nxt.comm_off = 1'b0;
          nxt.sess     = fwds_pkg::ST_SESSION;
        end
      end
      fwds_pkg::OP_SECURITY: begin
        if (ctx_i.sess != fwds_pkg::ST_SESSION) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (ctx_i.dtc_off && ctx_i.comm_off) begin
          nxt.sess = fwds_pkg::ST_QUIESCED;
        end else begin
          nxt.sess = fwds_pkg::ST_SECURED;
        end
      end
      fwds_pkg::OP_DTC, fwds_pkg::OP_COMM: begin
        if (!in_prog) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else begin
          if (item_i.operation == fwds_pkg::OP_DTC) begin
            nxt.dtc_off = item_i.flag_value;
          end else begin
            nxt.comm_off = item_i.flag_value;
          end
          // drop out of quiesced when a flag clears, then settle again
          if (!item_i.flag_value && fs == fwds_pkg::ST_QUIESCED) begin
            fs = cfg_i.need_sec_access ? fwds_pkg::ST_SECURED
                                       : fwds_pkg::ST_SESSION;
          end
          if (nxt.dtc_off && nxt.comm_off &&
              (fs == fwds_pkg::ST_SESSION || fs == fwds_pkg::ST_SECURED)) begin
            fs = fwds_pkg::ST_QUIESCED;
          end
          nxt.sess = fs;
        end
      end
      fwds_pkg::OP_DOWNLOAD: begin
        if (item_i.img_bytes == '0) begin
          st = fwds_pkg::RC_INVALID;
        end else if (!prereq) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (item_i.version <= ctx_i.inst_ver) begin
          st = fwds_pkg::RC_ROLLBACK;
        end else if (!item_i.first_ok || item_i.chosen_slot == NoSlot) begin
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else if (!item_i.second_ok) begin
          // hold the slot so the abort request names it
          nxt.cand_slot = item_i.chosen_slot;
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else begin
          nxt.cand_ver         = item_i.version;
          nxt.cand_bytes       = item_i.img_bytes;
          nxt.cand_slot        = item_i.chosen_slot;
          nxt.bytes_written    = '0;
          nxt.expected_counter = fwds_pkg::CntW'(1);
          nxt.sess             = fwds_pkg::ST_DOWNLOADING;
        end
      end
      fwds_pkg::OP_BLOCK: begin
        if (item_i.block_length == '0 || 32'(item_i.block_length) > MaxLen) begin
          st = fwds_pkg::RC_INVALID;
        end else if (ctx_i.sess != fwds_pkg::ST_DOWNLOADING) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (item_i.block_counter != ctx_i.expected_counter) begin
          st = fwds_pkg::RC_SEQUENCE;
        end else if (ctx_i.bytes_written > ctx_i.cand_bytes) begin
          st = fwds_pkg::RC_SIZE;
          fail = 1'b1;
        end else if (fwds_pkg::SizeW'(item_i.block_length) > room) begin
          st = fwds_pkg::RC_SIZE;
        end else begin
          offset = ctx_i.bytes_written;
          if (!item_i.first_ok) begin
            st = fwds_pkg::RC_HOOK;
            fail = 1'b1;
          end else begin
            nxt.bytes_written = ctx_i.bytes_written +
                                fwds_pkg::SizeW'(item_i.block_length);
            nxt.expected_counter = ctx_i.expected_counter + fwds_pkg::CntW'(1);
          end
        end
      end
      fwds_pkg::OP_EXIT: begin
        if (ctx_i.sess != fwds_pkg::ST_DOWNLOADING) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (ctx_i.bytes_written != ctx_i.cand_bytes) begin
          st = fwds_pkg::RC_SIZE;
        end else if (!item_i.first_ok) begin
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else begin
          nxt.sess = fwds_pkg::ST_TRANSFERRED;
        end
      end
      fwds_pkg::OP_CHECK: begin
        if (ctx_i.sess != fwds_pkg::ST_TRANSFERRED) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (!item_i.first_ok) begin
          st = fwds_pkg::RC_INTEGRITY;
          fail = 1'b1;
        end else if (cfg_i.need_auth && !item_i.second_ok) begin
          st = fwds_pkg::RC_AUTH;
          fail = 1'b1;
        end else begin
          nxt.sess = fwds_pkg::ST_VERIFIED;
        end
      end
      fwds_pkg::OP_STAGE: begin
        if (ctx_i.sess != fwds_pkg::ST_VERIFIED) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (!item_i.first_ok) begin
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else if (cfg_i.require_secure_boot_check && !item_i.second_ok) begin
          st = fwds_pkg::RC_SECBOOT;
          fail = 1'b1;
        end else begin
          nxt.sess = fwds_pkg::ST_STAGED;
        end
      end
      fwds_pkg::OP_CONFIRM: begin
        if (ctx_i.sess != fwds_pkg::ST_STAGED) begin
          st = fwds_pkg::RC_BAD_STATE;
        end else if (!item_i.first_ok) begin
          st = fwds_pkg::RC_HOOK;
          fail = 1'b1;
        end else begin
          nxt.inst_ver = ctx_i.cand_ver;
          nxt.sess = fwds_pkg::ST_COMPLETE;
        end
      end
      fwds_pkg::OP_ABORT: begin
        abort_req  = (ctx_i.cand_slot != NoSlot) && cfg_i.abort_hook_present;
        slot_out   = ctx_i.cand_slot;
        slot_fixed = 1'b1;
        nxt.cand_ver          = '0;
        nxt.cand_bytes        = '0;
        nxt.bytes_written     = '0;
        nxt.cand_slot         = NoSlot;
        nxt.expected_counter  = '0;
        nxt.dtc_off           = 1'b0;
        nxt.comm_off          = 1'b0;
        nxt.sess = cfg_i.prog_enable ? fwds_pkg::ST_ARMED : fwds_pkg::ST_DISARMED;
      end
      default: begin
        st = fwds_pkg::RC_INVALID;
      end
    endcase

    if (fail) begin
      nxt.sess  = fwds_pkg::ST_FAILED;
      abort_req = (nxt.cand_slot != NoSlot) && cfg_i.abort_hook_present;
    end
    if (!slot_fixed) begin
      slot_out = nxt.cand_slot;
    end

    ctx_o               = nxt;
    res_o.status        = st;
    res_o.sess          = nxt.sess;
    res_o.write_offset  = offset;
    res_o.target_slot   = slot_out;
    res_o.abort_request = abort_req;
  end

endmodule

// ===== hw/rtl/firmware_download_sequencer_top.sv =====
// Top level of the firmware download sequencer: handshake, state and config registers.
//
//   channel   dir   handshake              payload
//   in        in    in_valid_i/in_stall_o   operation .. chosen_slot
//   out       out   out_valid_o/out_stall_i status .. abort_request
//   cfg       in    cfg_we_i               cfg_index_i, cfg_data_i
//
// A transfer loads the input register; the step logic loads the result register and
// the state once the output side is free; out_valid_o rises as the result loads.
// One operation is accepted every cycle while the output side takes results.
// A stall on the output holds the result register and the input register in place.
// Reset clears the session state and the config registers to their defaults.
module firmware_download_sequencer_top #(
  parameter int unsigned MAX_BLOCK_BYTES = fwds_pkg::MaxBlockBytes,
  parameter int unsigned NO_SLOT_CODE    = fwds_pkg::NoSlotCode
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fwds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fwds_pkg::OpW-1:0]      operation_i,
  input  logic                          flag_value_i,
  input  logic [fwds_pkg::VerW-1:0]     version_i,
  input  logic [fwds_pkg::SizeW-1:0]    img_bytes_i,
  input  logic [fwds_pkg::CntW-1:0]     block_counter_i,
  input  logic [fwds_pkg::LenW-1:0]     block_length_i,
  input  logic                          first_ok_i,
  input  logic                          second_ok_i,
  input  logic [fwds_pkg::SlotW-1:0]    chosen_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fwds_pkg::StatusW-1:0]  status_o,
  output logic [fwds_pkg::StateW-1:0]   session_state_o,
  output logic [fwds_pkg::SizeW-1:0]    write_offset_o,
  output logic [fwds_pkg::SlotW-1:0]    target_slot_o,
  output logic                          abort_request_o
);

  fwds_pkg::cfg_t    cfg_q;
  fwds_pkg::ctx_t    ctx_q, ctx_d;
  fwds_pkg::item_t   item_q;
  fwds_pkg::result_t res_q, res_d;
  logic              item_vld_q;
  logic              out_vld_q;
  logic              out_free;
  logic              advance;
  logic              take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = item_vld_q && out_free;
  assign in_stall_o = item_vld_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prog_enable: 1'b0, need_sec_access: 1'b1,
                 need_quiet: 1'b1, need_auth: 1'b1,
                 require_secure_boot_check: 1'b1, hooks_complete: 1'b0,
                 abort_hook_present: 1'b0};
    end else if (cfg_we_i) begin
      unique case (fwds_pkg::cfg_idx_e'(cfg_index_i))
        fwds_pkg::CFG_ALLOW_PROG:  cfg_q.prog_enable               <= cfg_data_i;
        fwds_pkg::CFG_REQ_SEC:     cfg_q.need_sec_access           <= cfg_data_i;
        fwds_pkg::CFG_REQ_QUIESCE: cfg_q.need_quiet                <= cfg_data_i;
        fwds_pkg::CFG_REQ_AUTH:    cfg_q.need_auth                 <= cfg_data_i;
        fwds_pkg::CFG_REQ_SECBOOT: cfg_q.require_secure_boot_check <= cfg_data_i;
        fwds_pkg::CFG_HOOKS_DONE:  cfg_q.hooks_complete            <= cfg_data_i;
        fwds_pkg::CFG_ABORT_HOOK:  cfg_q.abort_hook_present        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fwds_step #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
    .NO_SLOT_CODE   (NO_SLOT_CODE)
  ) u_step (
    .cfg_i (cfg_q),
    .ctx_i (ctx_q),
    .item_i(item_q),
    .ctx_o (ctx_d),
    .res_o (res_d)
  );

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      ctx_q      <= '{sess: fwds_pkg::ST_DISARMED, inst_ver: '0,
                      cand_ver: '0, cand_bytes: '0, bytes_written: '0,
                      cand_slot: fwds_pkg::SlotW'(NO_SLOT_CODE),
                      expected_counter: '0, dtc_off: 1'b0, comm_off: 1'b0};
    end else begin
      if (take) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        ctx_q     <= ctx_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{operation: operation_i, flag_value: flag_value_i, version: version_i,
                  img_bytes: img_bytes_i, block_counter: block_counter_i,
                  block_length: block_length_i, first_ok: first_ok_i,
                  second_ok: second_ok_i, chosen_slot: chosen_slot_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = res_q.status;
  assign session_state_o = res_q.sess;
  assign write_offset_o  = res_q.write_offset;
  assign target_slot_o   = res_q.target_slot;
  assign abort_request_o = res_q.abort_request;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q && out_vld_q)
    else $error("input stalled with free pipeline");

  a_abort_names_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.abort_request |->
      res_q.target_slot != fwds_pkg::SlotW'(NO_SLOT_CODE))
    else $error("abort request without slot");

  a_abort_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.abort_request |->
      res_q.sess == fwds_pkg::ST_FAILED ||
      (res_q.status == fwds_pkg::RC_OK &&
       (res_q.sess == fwds_pkg::ST_ARMED || res_q.sess == fwds_pkg::ST_DISARMED)))
    else $error("abort request in wrong state");

  a_offset_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.write_offset != '0 |->
      res_q.status == fwds_pkg::RC_OK || res_q.status == fwds_pkg::RC_HOOK)
    else $error("write offset without write");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(res_q) && $stable(ctx_q))
    else $error("stalled result or state changed");

endmodule
